### sv/lpwd_pkg.sv
`default_nettype none

package lpwd_pkg;

	// default sizes handed to the top level parameters
	localparam int DURATION_BITS_DEFAULT = 15;
	localparam int COUNT_BITS_DEFAULT    = 16;

	// configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_LOW  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_HIGH  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_LOW   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_MIN = 3'd4;

	// window slots in the window register array
	localparam int NUM_WINDOWS = 4;
	localparam logic [1:0] WIN_ZERO_HIGH = 2'd0;
	localparam logic [1:0] WIN_ZERO_LOW  = 2'd1;
	localparam logic [1:0] WIN_ONE_HIGH  = 2'd2;
	localparam logic [1:0] WIN_ONE_LOW   = 2'd3;

	// reset pulse threshold; the default can never match a duration
	localparam int RESET_MIN_BITS = 16;
	localparam logic [RESET_MIN_BITS-1:0] RESET_MIN_DEFAULT = 16'd32768;

	// result counters as seen on the port
	localparam int OUT_COUNT_BITS = 16;

	// classification of one symbol
	typedef struct packed {
		logic is_reset;
		logic bit_ok;
		logic bit_val;
	} sym_class_t;

endpackage

`default_nettype wire

### sv/lpwd_sym_if.sv
`default_nettype none

interface lpwd_sym_if #(
	parameter int DURATION_BITS = lpwd_pkg::DURATION_BITS_DEFAULT
);
	logic                     valid;
	logic                     ready;
	logic                     first_level;
	logic [DURATION_BITS-1:0] first_duration;
	logic                     second_level;
	logic [DURATION_BITS-1:0] second_duration;
	logic                     last_symbol;

	modport source (
		output valid, first_level, first_duration, second_level, second_duration,
			last_symbol,
		input  ready
	);
	modport sink (
		input  valid, first_level, first_duration, second_level, second_duration,
			last_symbol,
		output ready
	);
endinterface

`default_nettype wire

### sv/lpwd_res_if.sv
`default_nettype none

interface lpwd_res_if;
	logic                                valid;
	logic                                ready;
	logic [7:0]                          data_byte;
	logic                                byte_valid;
	logic                                frame_done;
	logic                                success;
	logic [lpwd_pkg::OUT_COUNT_BITS-1:0] invalid_count;
	logic [lpwd_pkg::OUT_COUNT_BITS-1:0] bytes_so_far;

	modport source (
		output valid, data_byte, byte_valid, frame_done, success, invalid_count,
			bytes_so_far,
		input  ready
	);
	modport sink (
		input  valid, data_byte, byte_valid, frame_done, success, invalid_count,
			bytes_so_far,
		output ready
	);
endinterface

`default_nettype wire

### sv/lpwd_cfg_if.sv
`default_nettype none

interface lpwd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [lpwd_pkg::CFG_INDEX_BITS-1:0] index;
	logic [lpwd_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/lpwd_cfg.sv
`default_nettype none

module lpwd_cfg #(
	parameter int DURATION_BITS = lpwd_pkg::DURATION_BITS_DEFAULT
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	lpwd_cfg_if.sink                                        cfg,
	output logic [lpwd_pkg::NUM_WINDOWS-1:0][2*DURATION_BITS-1:0] windows,
	output logic [lpwd_pkg::RESET_MIN_BITS-1:0]             reset_min
);

	logic [lpwd_pkg::NUM_WINDOWS-1:0][2*DURATION_BITS-1:0] windows_q;
	logic [lpwd_pkg::RESET_MIN_BITS-1:0]                    reset_min_q;
	logic                                                   wr;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows_q   <= '0;
			reset_min_q <= lpwd_pkg::RESET_MIN_DEFAULT;
		end else if (wr) begin
			case (cfg.index)
				lpwd_pkg::REG_ZERO_HIGH: begin
					windows_q[lpwd_pkg::WIN_ZERO_HIGH] <= cfg.data[2*DURATION_BITS-1:0];
				end
				lpwd_pkg::REG_ZERO_LOW: begin
					windows_q[lpwd_pkg::WIN_ZERO_LOW] <= cfg.data[2*DURATION_BITS-1:0];
				end
				lpwd_pkg::REG_ONE_HIGH: begin
					windows_q[lpwd_pkg::WIN_ONE_HIGH] <= cfg.data[2*DURATION_BITS-1:0];
				end
				lpwd_pkg::REG_ONE_LOW: begin
					windows_q[lpwd_pkg::WIN_ONE_LOW] <= cfg.data[2*DURATION_BITS-1:0];
				end
				lpwd_pkg::REG_RESET_MIN: begin
					reset_min_q <= cfg.data[lpwd_pkg::RESET_MIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign windows   = windows_q;
	assign reset_min = reset_min_q;

endmodule

`default_nettype wire

### sv/lpwd_classify.sv
`default_nettype none

module lpwd_classify #(
	parameter int DURATION_BITS = lpwd_pkg::DURATION_BITS_DEFAULT
) (
	input  wire logic                                             first_level,
	input  wire logic [DURATION_BITS-1:0]                         first_duration,
	input  wire logic                                             second_level,
	input  wire logic [DURATION_BITS-1:0]                         second_duration,
	input  wire logic [lpwd_pkg::NUM_WINDOWS-1:0][2*DURATION_BITS-1:0] windows,
	input  wire logic [lpwd_pkg::RESET_MIN_BITS-1:0]              reset_min,
	output lpwd_pkg::sym_class_t                                  cls
);

	localparam int CMP_BITS = lpwd_pkg::RESET_MIN_BITS + 1;

	// min in the low half, max in the high half; min > max never matches
	function automatic logic in_window(input logic [2*DURATION_BITS-1:0] win,
			input logic [DURATION_BITS-1:0] d);
		logic [DURATION_BITS-1:0] lo;
		logic [DURATION_BITS-1:0] hi;
		lo = win[DURATION_BITS-1:0];
		hi = win[2*DURATION_BITS-1:DURATION_BITS];
		return (d >= lo) && (d <= hi);
	endfunction

	logic first_reset;
	logic second_reset;
	logic shape_ok;
	logic zero_match;
	logic one_match;

	// reset pulse test on either low half
	assign first_reset  = !first_level &&
		(CMP_BITS'(first_duration) >= CMP_BITS'(reset_min));
	assign second_reset = !second_level &&
		(CMP_BITS'(second_duration) >= CMP_BITS'(reset_min));

	// bit windows, bit 0 wins when both match
	assign shape_ok   = first_level && !second_level;
	assign zero_match = shape_ok &&
		in_window(windows[lpwd_pkg::WIN_ZERO_HIGH], first_duration) &&
		in_window(windows[lpwd_pkg::WIN_ZERO_LOW], second_duration);
	assign one_match  = shape_ok &&
		in_window(windows[lpwd_pkg::WIN_ONE_HIGH], first_duration) &&
		in_window(windows[lpwd_pkg::WIN_ONE_LOW], second_duration);

	assign cls.is_reset = first_reset || second_reset;
	assign cls.bit_ok   = zero_match || one_match;
	assign cls.bit_val  = !zero_match;

endmodule

`default_nettype wire

### sv/lpwd_frame.sv
`default_nettype none

module lpwd_frame #(
	parameter int COUNT_BITS = lpwd_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	input  wire lpwd_pkg::sym_class_t item_cls,
	input  wire logic                 item_last,
	output logic                      item_taken,
	lpwd_res_if.source                res
);

	localparam int OCB      = lpwd_pkg::OUT_COUNT_BITS;
	localparam int PROD_BITS = COUNT_BITS + 4;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [OCB-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		return (wide > 32'(16'hFFFF)) ? 16'hFFFF : wide[OCB-1:0];
	endfunction

	// left align a partial byte of pos bits
	function automatic logic [7:0] flush(input logic [7:0] sh, input logic [2:0] pos);
		logic [3:0] amt;
		amt = 4'd8 - {1'b0, pos};
		return sh << amt;
	endfunction

	logic [7:0]            shift_q;
	logic [2:0]            pos_q;
	logic [COUNT_BITS-1:0] err_q;
	logic [COUNT_BITS-1:0] sym_q;
	logic [COUNT_BITS-1:0] byte_q;
	logic                  stopped_q;

	logic [7:0]            shift_n;
	logic [2:0]            pos_n;
	logic [COUNT_BITS-1:0] err_n;
	logic [COUNT_BITS-1:0] sym_n;
	logic [COUNT_BITS-1:0] byte_n;
	logic                  stopped_n;
	logic                  have_byte;
	logic [7:0]            byte_val;
	logic [7:0]            shifted;
	logic                  produce;
	logic                  success;
	logic [PROD_BITS-1:0]  err_times_ten;

	logic                  res_valid_q;
	logic [7:0]            res_byte_q;
	logic                  res_byte_valid_q;
	logic                  res_done_q;
	logic                  res_success_q;
	logic [OCB-1:0]        res_invalid_q;
	logic [OCB-1:0]        res_bytes_q;
	logic                  out_free;

	// next frame state for the symbol in the input stage
	always_comb begin
		shift_n   = shift_q;
		pos_n     = pos_q;
		err_n     = err_q;
		stopped_n = stopped_q;
		sym_n     = sat_inc(sym_q);
		have_byte = 1'b0;
		byte_val  = 8'd0;
		shifted   = {shift_q[6:0], item_cls.bit_val};
		if (!stopped_q) begin
			if (item_cls.is_reset) begin
				if (pos_q != 3'd0) begin
					byte_val  = flush(shift_q, pos_q);
					have_byte = 1'b1;
					pos_n     = 3'd0;
					shift_n   = 8'd0;
				end
				stopped_n = 1'b1;
			end else if (!item_cls.bit_ok) begin
				err_n = sat_inc(err_q);
			end else if (pos_q == 3'd7) begin
				byte_val  = shifted;
				have_byte = 1'b1;
				pos_n     = 3'd0;
				shift_n   = 8'd0;
			end else begin
				shift_n = shifted;
				pos_n   = pos_q + 3'd1;
			end
		end
		// end of buffer flushes what is left
		if (item_last && !have_byte && pos_n != 3'd0) begin
			byte_val  = flush(shift_n, pos_n);
			have_byte = 1'b1;
			pos_n     = 3'd0;
			shift_n   = 8'd0;
		end
		byte_n  = have_byte ? sat_inc(byte_q) : byte_q;
		produce = have_byte || item_last;
	end

	// errors < symbols / 10  is the same as  10 * errors + 10 <= symbols
	assign err_times_ten = (PROD_BITS'(err_n) << 3) + (PROD_BITS'(err_n) << 1);
	assign success       = item_last &&
		((err_times_ten + PROD_BITS'(10)) <= PROD_BITS'(sym_n));

	// take the symbol unless its result has nowhere to go
	assign out_free   = !res_valid_q || res.ready;
	assign item_taken = item_valid && (!produce || out_free);

	// frame state; the last symbol clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			pos_q     <= '0;
			err_q     <= '0;
			sym_q     <= '0;
			byte_q    <= '0;
			stopped_q <= 1'b0;
		end else if (item_taken) begin
			if (item_last) begin
				shift_q   <= '0;
				pos_q     <= '0;
				err_q     <= '0;
				sym_q     <= '0;
				byte_q    <= '0;
				stopped_q <= 1'b0;
			end else begin
				shift_q   <= shift_n;
				pos_q     <= pos_n;
				err_q     <= err_n;
				sym_q     <= sym_n;
				byte_q    <= byte_n;
				stopped_q <= stopped_n;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= item_taken && produce;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (item_taken && produce) begin
			res_byte_q       <= have_byte ? byte_val : 8'd0;
			res_byte_valid_q <= have_byte;
			res_done_q       <= item_last;
			res_success_q    <= success;
			res_invalid_q    <= clip_out(err_n);
			res_bytes_q      <= clip_out(byte_n);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.data_byte     = res_byte_q;
	assign res.byte_valid    = res_byte_valid_q;
	assign res.frame_done    = res_done_q;
	assign res.success       = res_success_q;
	assign res.invalid_count = res_invalid_q;
	assign res.bytes_so_far  = res_bytes_q;

endmodule

`default_nettype wire

### sv/led_pulse_width_bit_decoder.sv
// a symbol accepted into the input stage has its result registered when the frame stage takes it
// throughput: one symbol per cycle; the input stage stalls only when a result is pending
// and the result register is still held by the sink
// reset: arst_n clears the frame state and both stage valids, window registers go to zero
// and the reset threshold to 32768, which never matches

`default_nettype none

module led_pulse_width_bit_decoder #(
	parameter int DURATION_BITS = lpwd_pkg::DURATION_BITS_DEFAULT,
	parameter int COUNT_BITS    = lpwd_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpwd_sym_if.sink   sym,
	lpwd_cfg_if.sink   cfg,
	lpwd_res_if.source res
);

	logic [lpwd_pkg::NUM_WINDOWS-1:0][2*DURATION_BITS-1:0] windows;
	logic [lpwd_pkg::RESET_MIN_BITS-1:0]                    reset_min;

	logic                     valid_s1;
	logic                     first_level_s1;
	logic [DURATION_BITS-1:0] first_duration_s1;
	logic                     second_level_s1;
	logic [DURATION_BITS-1:0] second_duration_s1;
	logic                     last_s1;
	logic                     taken;
	logic                     sym_req;
	lpwd_pkg::sym_class_t     cls;

	lpwd_cfg #(
		.DURATION_BITS (DURATION_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.windows   (windows),
		.reset_min (reset_min)
	);

	// input stage takes a request when empty or draining
	assign sym.ready = !valid_s1 || taken;
	assign sym_req   = sym.valid && sym.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym.ready) begin
			valid_s1 <= sym.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_req) begin
			first_level_s1     <= sym.first_level;
			first_duration_s1  <= sym.first_duration;
			second_level_s1    <= sym.second_level;
			second_duration_s1 <= sym.second_duration;
			last_s1            <= sym.last_symbol;
		end
	end

	lpwd_classify #(
		.DURATION_BITS (DURATION_BITS)
	) u_classify (
		.first_level     (first_level_s1),
		.first_duration  (first_duration_s1),
		.second_level    (second_level_s1),
		.second_duration (second_duration_s1),
		.windows         (windows),
		.reset_min       (reset_min),
		.cls             (cls)
	);

	lpwd_frame #(
		.COUNT_BITS (COUNT_BITS)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_cls   (cls),
		.item_last  (last_s1),
		.item_taken (taken),
		.res        (res)
	);

endmodule

`default_nettype wire

### bench/tb_led_pulse_width_bit_decoder.sv
`timescale 1ns / 100ps

module tb_led_pulse_width_bit_decoder;
	import lpwd_pkg::*;

	localparam int DUR_BITS     = DURATION_BITS_DEFAULT;
	localparam int CNT_BITS     = COUNT_BITS_DEFAULT;
	localparam int DUR_TOP      = (1 << DUR_BITS) - 1;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 400;
	localparam int MAX_PRINTED  = 40;
	localparam longint CYCLE_LIMIT = 3000000;

	// index that decodes to no register
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic                first_level;
		logic [DUR_BITS-1:0] first_duration;
		logic                second_level;
		logic [DUR_BITS-1:0] second_duration;
		logic                last_symbol;
	} symbol_t;

	typedef struct packed {
		logic [7:0]                data_byte;
		logic                      byte_valid;
		logic                      frame_done;
		logic                      success;
		logic [OUT_COUNT_BITS-1:0] invalid_count;
		logic [OUT_COUNT_BITS-1:0] bytes_so_far;
	} decode_result_t;

	typedef enum int {KIND_BIT, KIND_EDGE, KIND_RESET, KIND_NOISE} symbol_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	lpwd_sym_if #(.DURATION_BITS(DUR_BITS)) sym_bus ();
	lpwd_cfg_if cfg_bus ();
	lpwd_res_if res_bus ();

	led_pulse_width_bit_decoder #(
		.DURATION_BITS(DUR_BITS),
		.COUNT_BITS(CNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sym(sym_bus),
		.cfg(cfg_bus),
		.res(res_bus)
	);

	// register copies
	logic [2*DUR_BITS-1:0] window_reg [NUM_WINDOWS];
	logic [RESET_MIN_BITS-1:0] reset_thresh;

	// frame state of the decoder
	logic [7:0]          line_shift;
	int                  line_bits;
	logic [CNT_BITS-1:0] err_count;
	logic [CNT_BITS-1:0] sym_count;
	logic [CNT_BITS-1:0] byte_count;
	logic                frame_halted;

	decode_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	int mismatches = 0;
	int symbols_sent = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	longint cycle_count = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic void clear_frame();
		line_shift = '0;
		line_bits = 0;
		err_count = '0;
		sym_count = '0;
		byte_count = '0;
		frame_halted = 1'b0;
	endfunction

	function automatic bit in_window(input logic [2*DUR_BITS-1:0] w,
			input logic [DUR_BITS-1:0] d);
		return d >= w[DUR_BITS-1:0] && d <= w[2*DUR_BITS-1:DUR_BITS];
	endfunction

	// work out the result of one accepted symbol and queue it
	function automatic void decode_symbol(input symbol_t s);
		decode_result_t r;
		logic           have_byte;
		logic [7:0]     out_byte;
		int             bit_val;
		have_byte = 1'b0;
		out_byte = '0;
		sym_count = sat_inc(sym_count);
		if (!frame_halted) begin
			if ((!s.first_level && {1'b0, s.first_duration} >= reset_thresh) ||
			    (!s.second_level && {1'b0, s.second_duration} >= reset_thresh)) begin
				// reset pulse: flush a partial byte and stop the frame
				if (line_bits != 0) begin
					out_byte = line_shift << (8 - line_bits);
					have_byte = 1'b1;
					line_shift = '0;
					line_bits = 0;
				end
				frame_halted = 1'b1;
			end else begin
				bit_val = -1;
				if (s.first_level && !s.second_level) begin
					if (in_window(window_reg[WIN_ZERO_HIGH], s.first_duration) &&
					    in_window(window_reg[WIN_ZERO_LOW], s.second_duration))
						bit_val = 0;
					else if (in_window(window_reg[WIN_ONE_HIGH], s.first_duration) &&
					         in_window(window_reg[WIN_ONE_LOW], s.second_duration))
						bit_val = 1;
				end
				if (bit_val < 0) begin
					err_count = sat_inc(err_count);
				end else begin
					line_shift = {line_shift[6:0], bit_val[0]};
					line_bits++;
					if (line_bits == 8) begin
						out_byte = line_shift;
						have_byte = 1'b1;
						line_shift = '0;
						line_bits = 0;
					end
				end
			end
		end
		// end of buffer flushes whatever is left
		if (s.last_symbol && !have_byte && line_bits != 0) begin
			out_byte = line_shift << (8 - line_bits);
			have_byte = 1'b1;
			line_shift = '0;
			line_bits = 0;
		end
		if (have_byte)
			byte_count = sat_inc(byte_count);
		if (have_byte || s.last_symbol) begin
			r.data_byte = have_byte ? out_byte : 8'd0;
			r.byte_valid = have_byte;
			r.frame_done = s.last_symbol;
			r.success = s.last_symbol && (err_count < sym_count / 10);
			r.invalid_count = err_count;
			r.bytes_so_far = byte_count;
			pending_results.push_back(r);
		end
		if (s.last_symbol)
			clear_frame();
	endfunction

	function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			REG_ZERO_HIGH: window_reg[WIN_ZERO_HIGH] = value[2*DUR_BITS-1:0];
			REG_ZERO_LOW:  window_reg[WIN_ZERO_LOW]  = value[2*DUR_BITS-1:0];
			REG_ONE_HIGH:  window_reg[WIN_ONE_HIGH]  = value[2*DUR_BITS-1:0];
			REG_ONE_LOW:   window_reg[WIN_ONE_LOW]   = value[2*DUR_BITS-1:0];
			REG_RESET_MIN: reset_thresh = value[RESET_MIN_BITS-1:0];
			default: ;
		endcase
	endfunction

	function automatic symbol_t make_symbol(input logic l0, input int d0, input logic l1,
			input int d1, input logic fin);
		symbol_t s;
		s.first_level = l0;
		s.first_duration = DUR_BITS'(d0);
		s.second_level = l1;
		s.second_duration = DUR_BITS'(d1);
		s.last_symbol = fin;
		return s;
	endfunction

	// window word with random filler in the unused top bits
	function automatic logic [CFG_DATA_BITS-1:0] window_word(input int lo, input int hi);
		return {2'($urandom_range(0, 3)), DUR_BITS'(hi), DUR_BITS'(lo)};
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] random_window_word();
		int lo, hi, t;
		lo = ($urandom_range(0, 9) == 0) ? $urandom_range(16384, DUR_TOP) :
			$urandom_range(0, 3000);
		hi = lo + $urandom_range(0, 400);
		if (hi > DUR_TOP)
			hi = DUR_TOP;
		// now and then an inverted window
		if ($urandom_range(0, 11) == 0) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		return window_word(lo, hi);
	endfunction

	function automatic int pick_duration(input logic [2*DUR_BITS-1:0] w, input bit off_by_one);
		int lo, hi;
		lo = w[DUR_BITS-1:0];
		hi = w[2*DUR_BITS-1:DUR_BITS];
		if (off_by_one)
			return $urandom_range(0, 1) ? ((lo - 1) & DUR_TOP) : ((hi + 1) & DUR_TOP);
		case ($urandom_range(0, 4))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// mostly well formed bits, some window edges, reset pulses and noise
	function automatic symbol_t random_symbol();
		symbol_t      s;
		symbol_kind_t kind;
		int           roll;
		logic         bit_val;
		logic [1:0]   hi_slot, lo_slot;
		roll = $urandom_range(0, 99);
		kind = (roll < 80) ? KIND_BIT : (roll < 88) ? KIND_EDGE :
			(roll < 94) ? KIND_RESET : KIND_NOISE;
		bit_val = 1'($urandom_range(0, 1));
		hi_slot = bit_val ? WIN_ONE_HIGH : WIN_ZERO_HIGH;
		lo_slot = bit_val ? WIN_ONE_LOW : WIN_ZERO_LOW;
		s = make_symbol(1'b1, pick_duration(window_reg[hi_slot], 1'b0), 1'b0,
			pick_duration(window_reg[lo_slot], 1'b0), 1'b0);
		case (kind)
			KIND_EDGE: begin
				if ($urandom_range(0, 1))
					s.first_duration = DUR_BITS'(pick_duration(window_reg[hi_slot], 1'b1));
				else
					s.second_duration = DUR_BITS'(pick_duration(window_reg[lo_slot], 1'b1));
			end
			KIND_RESET: begin
				if (reset_thresh <= DUR_TOP) begin
					if ($urandom_range(0, 1)) begin
						s.first_level = 1'b0;
						s.first_duration = DUR_BITS'($urandom_range(reset_thresh, DUR_TOP));
					end else begin
						s.second_duration = DUR_BITS'($urandom_range(reset_thresh, DUR_TOP));
					end
				end
			end
			KIND_NOISE: begin
				s = make_symbol(1'($urandom_range(0, 1)), $urandom_range(0, DUR_TOP),
					1'($urandom_range(0, 1)), $urandom_range(0, DUR_TOP), 1'b0);
			end
			default: ;
		endcase
		return s;
	endfunction

	// one symbol request, with random idle cycles ahead of it
	task automatic send_symbol(input symbol_t s);
		int gap;
		gap = 0;
		while (gap < 50 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			sym_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sym_bus.valid <= 1'b1;
		sym_bus.first_level <= s.first_level;
		sym_bus.first_duration <= s.first_duration;
		sym_bus.second_level <= s.second_level;
		sym_bus.second_duration <= s.second_duration;
		sym_bus.last_symbol <= s.last_symbol;
		@(posedge clk);
		while (!sym_bus.ready)
			@(posedge clk);
		decode_symbol(s);
		symbols_sent++;
		if (s.last_symbol)
			frames_sent++;
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		apply_register(idx, value);
		reg_writes++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// drop the symbol request and let every result come out
	task automatic wait_drained();
		@(negedge clk);
		sym_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_random_frame();
		int      len;
		symbol_t s;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
		for (int i = 0; i < len; i++) begin
			s = random_symbol();
			s.last_symbol = (i == len - 1);
			send_symbol(s);
		end
	endtask

	task automatic program_fixed_windows();
		write_register(REG_ZERO_HIGH, window_word(4, 8));
		write_register(REG_ZERO_LOW, window_word(4, 8));
		write_register(REG_ONE_HIGH, window_word(12, 16));
		write_register(REG_ONE_LOW, window_word(4, 8));
		write_register(REG_RESET_MIN, CFG_DATA_BITS'(RESET_MIN_DEFAULT));
	endtask

	function automatic symbol_t fixed_bit_symbol(input logic fin);
		return make_symbol(1'b1, $urandom_range(0, 1) ? 14 : 6, 1'b0, 6, fin);
	endfunction

	// windows at zero and reset detection off straight after reset
	task automatic test_reset_defaults();
		send_symbol(make_symbol(1'b1, 0, 1'b0, 0, 1'b0));
		send_symbol(make_symbol(1'b0, DUR_TOP, 1'b0, DUR_TOP, 1'b1));
		wait_drained();
	endtask

	// window bounds, bad levels, byte assembly and a byte on the last symbol
	task automatic test_bit_decoding();
		write_register(REG_ZERO_HIGH, window_word(10, 20));
		write_register(REG_ZERO_LOW, window_word(30, 40));
		write_register(REG_ONE_HIGH, window_word(25, 35));
		write_register(REG_ONE_LOW, window_word(5, 15));
		write_register(REG_RESET_MIN, 32'hABCD_0064);
		write_register(REG_SPARE, 32'hFFFF_FFFF);
		send_symbol(make_symbol(1'b1, 10, 1'b0, 30, 1'b0));
		send_symbol(make_symbol(1'b1, 20, 1'b0, 40, 1'b0));
		send_symbol(make_symbol(1'b1, 25, 1'b0, 5, 1'b0));
		send_symbol(make_symbol(1'b1, 35, 1'b0, 15, 1'b0));
		send_symbol(make_symbol(1'b0, 15, 1'b1, 35, 1'b0));
		send_symbol(make_symbol(1'b1, 9, 1'b0, 30, 1'b0));
		send_symbol(make_symbol(1'b1, 20, 1'b0, 41, 1'b0));
		send_symbol(make_symbol(1'b1, 30, 1'b0, 10, 1'b0));
		send_symbol(make_symbol(1'b1, 15, 1'b0, 35, 1'b0));
		send_symbol(make_symbol(1'b1, 30, 1'b0, 10, 1'b0));
		send_symbol(make_symbol(1'b1, 30, 1'b0, 10, 1'b1));
		wait_drained();
	endtask

	// overlapping, full and inverted windows, reset on either half
	task automatic test_special_cases();
		write_register(REG_ZERO_HIGH, window_word(0, DUR_TOP));
		write_register(REG_ZERO_LOW, window_word(0, DUR_TOP));
		write_register(REG_ONE_HIGH, window_word(0, DUR_TOP));
		write_register(REG_ONE_LOW, window_word(0, DUR_TOP));
		write_register(REG_RESET_MIN, DUR_TOP);
		// both windows match, then a reset on the second half flushes one bit
		send_symbol(make_symbol(1'b1, DUR_TOP, 1'b0, 0, 1'b0));
		send_symbol(make_symbol(1'b1, 0, 1'b0, DUR_TOP, 1'b0));
		send_symbol(make_symbol(1'b0, 0, 1'b1, 0, 1'b1));
		wait_drained();
		// inverted windows never match
		write_register(REG_ZERO_HIGH, window_word(20, 10));
		write_register(REG_ONE_HIGH, window_word(20, 10));
		write_register(REG_RESET_MIN, 32'h0000_FFFF);
		send_symbol(make_symbol(1'b1, 15, 1'b0, 7, 1'b1));
		wait_drained();
		// zero threshold: any low half resets, first half without a partial byte
		write_register(REG_RESET_MIN, 32'hFFFF_0000);
		send_symbol(make_symbol(1'b0, 0, 1'b1, DUR_TOP, 1'b0));
		send_symbol(make_symbol(1'b1, DUR_TOP, 1'b1, DUR_TOP, 1'b1));
		wait_drained();
	endtask

	// random settings under four idle and stall mixes
	task automatic test_random_traffic();
		int send_mix [4] = '{0, 75, 0, 6};
		int recv_mix [4] = '{0, 0, 75, 6};
		int start;
		int top_low;
		for (int p = 0; p < 4; p++) begin
			write_register(REG_ZERO_HIGH, random_window_word());
			write_register(REG_ZERO_LOW, random_window_word());
			write_register(REG_ONE_HIGH, random_window_word());
			write_register(REG_ONE_LOW, random_window_word());
			top_low = window_reg[WIN_ZERO_LOW][2*DUR_BITS-1:DUR_BITS];
			if (window_reg[WIN_ONE_LOW][2*DUR_BITS-1:DUR_BITS] > top_low)
				top_low = window_reg[WIN_ONE_LOW][2*DUR_BITS-1:DUR_BITS];
			// threshold mostly above the low windows, sometimes tiny or off
			case ($urandom_range(0, 9))
				0: write_register(REG_RESET_MIN, $urandom | CFG_DATA_BITS'(RESET_MIN_DEFAULT));
				1: write_register(REG_RESET_MIN, {16'($urandom), 16'($urandom_range(0, 40))});
				default: write_register(REG_RESET_MIN, {16'($urandom),
					16'((top_low >= DUR_TOP) ? RESET_MIN_DEFAULT :
					$urandom_range(top_low + 1, DUR_TOP))});
			endcase
			send_idle_pct = send_mix[p];
			recv_stall_pct = recv_mix[p];
			start = symbols_sent;
			while (symbols_sent - start < PHASE_ITEMS)
				send_random_frame();
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// long receiver hold-off while bytes keep coming
	task automatic test_backpressure();
		program_fixed_windows();
		@(negedge clk);
		hold_req = 1'b1;
		for (int i = 0; i < 64; i++)
			send_symbol(fixed_bit_symbol(i == 63));
		wait_drained();
	endtask

	// hold-off counter
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	// result request ready with random stalls
	always @(negedge clk) begin
		res_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// compare each result with the oldest expected one
	always @(posedge clk) begin : check_results
		decode_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected, data_byte",
					res_bus.data_byte, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_bus.data_byte !== want.data_byte)
					report_mismatch("data_byte", res_bus.data_byte, want.data_byte);
				if (res_bus.byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", res_bus.byte_valid, want.byte_valid);
				if (res_bus.frame_done !== want.frame_done)
					report_mismatch("frame_done", res_bus.frame_done, want.frame_done);
				if (res_bus.success !== want.success)
					report_mismatch("success", res_bus.success, want.success);
				if (res_bus.invalid_count !== want.invalid_count)
					report_mismatch("invalid_count", res_bus.invalid_count,
						want.invalid_count);
				if (res_bus.bytes_so_far !== want.bytes_so_far)
					report_mismatch("bytes_so_far", res_bus.bytes_so_far,
						want.bytes_so_far);
			end
		end
	end

	// cycle limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stopped after %0d cycles, %0d results outstanding", cycle_count,
			pending_results.size());
		$display("led_pulse_width_bit_decoder: mismatch");
		$finish;
	end

	initial begin
		sym_bus.valid = 1'b0;
		sym_bus.first_level = 1'b0;
		sym_bus.first_duration = '0;
		sym_bus.second_level = 1'b0;
		sym_bus.second_duration = '0;
		sym_bus.last_symbol = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		res_bus.ready = 1'b0;
		for (int w = 0; w < NUM_WINDOWS; w++)
			window_reg[w] = '0;
		reset_thresh = RESET_MIN_DEFAULT;
		clear_frame();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_bit_decoding();
		test_special_cases();
		test_random_traffic();
		test_backpressure();

		$display("%0d symbols in %0d frames, %0d results checked, %0d register writes",
			symbols_sent, frames_sent, results_seen, reg_writes);
		$display("window edges, reset pulses, stall mixes and a %0d-cycle hold-off",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("led_pulse_width_bit_decoder: match");
		else
			$display("led_pulse_width_bit_decoder: mismatch");
		$finish;
	end

endmodule

### files.f
sv/lpwd_pkg.sv
sv/lpwd_sym_if.sv
sv/lpwd_res_if.sv
sv/lpwd_cfg_if.sv
sv/lpwd_cfg.sv
sv/lpwd_classify.sv
sv/lpwd_frame.sv
sv/led_pulse_width_bit_decoder.sv
bench/tb_led_pulse_width_bit_decoder.sv
